// ----- src/assert_macros.svh -----
// Assertion macros shared by the RTL of the modular inverse block.
// Included by the modules that carry concurrent assertions; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define ASSERT_ALWAYS(label, clk, rst, expr) \
   label: assert property (@(posedge clk) disable iff (rst) (expr)) \
      else $error("assertion failed");
`define ASSERT_NEXT(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error("assertion failed");
`else
`define ASSERT_ALWAYS(label, clk, rst, expr)
`define ASSERT_NEXT(label, clk, rst, pre, post)
`endif
`endif

// ----- src/mie_pkg.sv -----
// Shared types and constants of the modular inverse block.
// Used by the controller, the datapath and the top level; no dependencies.
`timescale 1ns / 1ps
`default_nettype none
package mie_pkg;

   localparam logic [1:0] ST_OK      = 2'd0;
   localparam logic [1:0] ST_NOINV   = 2'd1;
   localparam logic [1:0] ST_MODZERO = 2'd2;

   typedef struct packed {
      logic load;
      logic up;
      logic down;
      logic norm;
      logic out;
   } cmd_type;

   typedef struct packed {
      logic mod_zero;
      logic curr_zero;
      logic up_ok;
      logic k_zero;
   } status_type;

endpackage
`default_nettype wire

// ----- src/mie_datapath.sv -----
// Datapath of the modular inverse block: remainders, coefficients and result register.
// Depends on mie_pkg for command, status and result codes.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module mie_datapath #(
   parameter int WIDTH = 31
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire mie_pkg::cmd_type     cmd,
   input  wire logic [WIDTH-1:0]     value,
   input  wire logic [WIDTH-1:0]     modulus,
   output mie_pkg::status_type       status,
   output logic [WIDTH-1:0]          inverse,
   output logic [1:0]                result_status
);

   localparam int KW = (WIDTH > 1) ? $clog2(WIDTH) : 1;
   localparam int CW = WIDTH + 2;

   logic [WIDTH-1:0] rem_prev_ff, rem_prev_in;
   logic [WIDTH-1:0] rem_curr_ff, rem_curr_in;
   logic [CW-1:0]    coef_prev_ff, coef_prev_in;
   logic [CW-1:0]    coef_curr_ff, coef_curr_in;
   logic [WIDTH-1:0] mod_ff, mod_in;
   logic             mod_zero_ff, mod_zero_in;
   logic [KW-1:0]    k_ff, k_in;
   logic [WIDTH-1:0] inv_ff, inv_in;
   logic [1:0]       status_ff, status_in;

   logic [KW:0]      k_inc;
   logic             sub_ok;
   logic [WIDTH-1:0] rem_red;
   logic [CW-1:0]    coef_red;
   logic [CW-1:0]    mod_ext;
   logic [CW-1:0]    coef_wrap;

   always_comb begin
      k_inc    = {1'b0, k_ff} + {{KW{1'b0}}, 1'b1};
      sub_ok   = rem_curr_ff <= (rem_prev_ff >> k_ff);
      rem_red  = sub_ok ? rem_prev_ff - (rem_curr_ff << k_ff) : rem_prev_ff;
      coef_red = sub_ok ? coef_prev_ff - (coef_curr_ff << k_ff) : coef_prev_ff;
      mod_ext  = {2'b00, mod_ff};
      coef_wrap = (coef_prev_ff >= mod_ext) ? coef_prev_ff - mod_ext : coef_prev_ff;

      status.mod_zero  = mod_zero_ff;
      status.curr_zero = rem_curr_ff == '0;
      status.up_ok     = rem_curr_ff <= (rem_prev_ff >> k_inc);
      status.k_zero    = k_ff == '0;
   end

   always_comb begin
      rem_prev_in  = rem_prev_ff;
      rem_curr_in  = rem_curr_ff;
      coef_prev_in = coef_prev_ff;
      coef_curr_in = coef_curr_ff;
      mod_in       = mod_ff;
      mod_zero_in  = mod_zero_ff;
      k_in         = k_ff;
      inv_in       = inv_ff;
      status_in    = status_ff;
      if (cmd.load) begin
         rem_prev_in  = value;
         rem_curr_in  = modulus;
         coef_prev_in = {{(CW-1){1'b0}}, 1'b1};
         coef_curr_in = '0;
         mod_in       = modulus;
         mod_zero_in  = modulus == '0;
         k_in         = '0;
      end
      if (cmd.up) begin
         k_in = k_inc[KW-1:0];
      end
      if (cmd.down) begin
         if (k_ff == '0) begin
            rem_prev_in  = rem_curr_ff;
            rem_curr_in  = rem_red;
            coef_prev_in = coef_curr_ff;
            coef_curr_in = coef_red;
         end else begin
            rem_prev_in  = rem_red;
            coef_prev_in = coef_red;
            k_in         = k_ff - {{(KW-1){1'b0}}, 1'b1};
         end
      end
      if (cmd.norm && coef_prev_ff[CW-1]) begin
         coef_prev_in = coef_prev_ff + mod_ext;
      end
      if (cmd.out) begin
         priority if (mod_zero_ff) begin
            status_in = mie_pkg::ST_MODZERO;
            inv_in    = '0;
         end else if (rem_prev_ff == {{(WIDTH-1){1'b0}}, 1'b1}) begin
            status_in = mie_pkg::ST_OK;
            inv_in    = coef_wrap[WIDTH-1:0];
         end else begin
            status_in = mie_pkg::ST_NOINV;
            inv_in    = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rem_prev_ff  <= '0;
         rem_curr_ff  <= '0;
         coef_prev_ff <= '0;
         coef_curr_ff <= '0;
         mod_ff       <= '0;
         inv_ff       <= '0;
         status_ff    <= mie_pkg::ST_OK;
         mod_zero_ff  <= 1'b0;
         k_ff         <= '0;
      end else begin
         rem_prev_ff  <= rem_prev_in;
         rem_curr_ff  <= rem_curr_in;
         coef_prev_ff <= coef_prev_in;
         coef_curr_ff <= coef_curr_in;
         mod_ff       <= mod_in;
         inv_ff       <= inv_in;
         status_ff    <= status_in;
         mod_zero_ff  <= mod_zero_in;
         k_ff         <= k_in;
      end
   end

   assign inverse       = inv_ff;
   assign result_status = status_ff;

   `ASSERT_ALWAYS(a_k_range, clock, reset, k_ff <= KW'(WIDTH - 1))
   `ASSERT_ALWAYS(a_round_rem, clock, reset, !(cmd.down && k_ff == '0) || rem_red < rem_curr_ff)
   `ASSERT_ALWAYS(a_status_code, clock, reset, status_ff <= mie_pkg::ST_MODZERO)

endmodule
`default_nettype wire

// ----- src/mie_ctrl.sv -----
// Controller of the modular inverse block: sequences rounds and owns the handshakes.
// Depends on mie_pkg for the command and status structures.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module mie_ctrl (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_tvalid,
   output logic                     req_tready,
   output logic                     rsp_tvalid,
   input  wire logic                rsp_tready,
   input  wire mie_pkg::status_type status,
   output mie_pkg::cmd_type         cmd
);

   typedef enum logic [5:0] {
      S_IDLE   = 6'b000001,
      S_CHECK  = 6'b000010,
      S_UP     = 6'b000100,
      S_DOWN   = 6'b001000,
      S_NORM   = 6'b010000,
      S_RESULT = 6'b100000
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;

   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      req_tready = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.load = 1'b1;
               state_in = S_CHECK;
            end
         end
         S_CHECK: begin
            priority if (status.mod_zero) state_in = S_RESULT;
            else if (status.curr_zero)    state_in = S_NORM;
            else                          state_in = S_UP;
         end
         S_UP: begin
            if (status.up_ok) begin
               cmd.up = 1'b1;
            end else begin
               state_in = S_DOWN;
            end
         end
         S_DOWN: begin
            cmd.down = 1'b1;
            if (status.k_zero) begin
               state_in = S_CHECK;
            end
         end
         S_NORM: begin
            cmd.norm = 1'b1;
            state_in = S_RESULT;
         end
         S_RESULT: begin
            if (!rsp_valid_ff || rsp_tready) begin
               cmd.out  = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
      rsp_valid_in = cmd.out || (rsp_valid_ff && !rsp_tready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;

   `ASSERT_NEXT(a_accept_check, clock, reset, req_tvalid && req_tready, state_ff == S_CHECK)
   `ASSERT_ALWAYS(a_out_free, clock, reset, !cmd.out || !rsp_valid_ff || rsp_tready)
   `ASSERT_ALWAYS(a_busy_blocks, clock, reset, !(state_ff == S_UP || state_ff == S_DOWN) || !req_tready)

endmodule
`default_nettype wire

// ----- src/modular_inverse_ext_euclid.sv -----
// Top level of the modular inverse block: stream ports, controller and datapath.
// Depends on mie_pkg, mie_ctrl and mie_datapath.
`timescale 1ns / 1ps
`default_nettype none
// Computes the inverse of a value modulo a modulus with the extended Euclidean
// algorithm, one request at a time, and returns one response per request with a
// status of ok, no inverse (gcd not one) or modulus zero. Each Euclid round finds
// its quotient by shift-and-subtract: the divisor is first doubled until it passes
// the dividend, then walked back down, subtracting the remainder and the shifted
// coefficient together, and is followed by a check state. The response sits in an
// output register, so a new request is taken as soon as it has been written.
module modular_inverse_ext_euclid #(
   parameter int WIDTH = 31
) (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 req_tvalid,
   output logic                                      req_tready,
   // value [WIDTH-1:0], modulus [2*WIDTH-1:WIDTH], zero padding above
   input  wire logic [((2*WIDTH+7)/8)*8-1:0]         req_tdata,
   output logic                                      rsp_tvalid,
   input  wire logic                                 rsp_tready,
   // inverse [WIDTH-1:0], zero padding above
   output logic [((WIDTH+7)/8)*8-1:0]                rsp_tdata,
   // status [1:0]
   output logic [1:0]                                rsp_tuser
);

   mie_pkg::cmd_type    cmd;
   mie_pkg::status_type status;
   logic [WIDTH-1:0]    inverse;

   mie_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .status     (status),
      .cmd        (cmd)
   );

   mie_datapath #(
      .WIDTH (WIDTH)
   ) u_datapath (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .value         (req_tdata[WIDTH-1:0]),
      .modulus       (req_tdata[2*WIDTH-1:WIDTH]),
      .status        (status),
      .inverse       (inverse),
      .result_status (rsp_tuser)
   );

   always_comb begin
      rsp_tdata              = '0;
      rsp_tdata[WIDTH-1:0]   = inverse;
   end

endmodule
`default_nettype wire
